[hdl/ctbs_pkg.sv]
// Shared constants and helpers for the comb-then-bubble sorter.
// Depends on nothing; used by comb_then_bubble_sorter_unit.
`default_nettype none

package ctbs_pkg;

  localparam int unsigned MAX_ITEMS_DEFAULT = 64;
  localparam int unsigned VALUE_W           = 7;

  // gap_next = floor(gap * GAP_NUM / GAP_DEN), taken as a reciprocal multiply plus one fix-up
  localparam int unsigned GAP_NUM     = 1000;
  localparam int unsigned GAP_NUM_W   = 10;
  localparam int unsigned GAP_DEN     = 1247;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned GAP_RECIP   = (GAP_NUM << RECIP_SHIFT) / GAP_DEN;

  // v / 10 as (v * 205) >> 11, exact for every 7-bit v
  localparam int unsigned TENS_MUL   = 205;
  localparam int unsigned TENS_SHIFT = 11;
  localparam int unsigned TENS_PW    = 15;

  function automatic logic [3:0] tens_digit(input logic [VALUE_W-1:0] v);
    logic [TENS_PW-1:0] p;
    p = TENS_PW'(v) * TENS_PW'(TENS_MUL);
    return p[TENS_PW-1:TENS_SHIFT];
  endfunction

endpackage

`default_nettype wire

[hdl/ctbs_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
`default_nettype none

module ctbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                         rdata_a,
  output logic      [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[hdl/comb_then_bubble_sorter_unit.sv]
// Top level of the comb-then-bubble sorter: load, comb pre-pass on tens digit,
// bubble finish, ordered readout. Depends on ctbs_pkg and ctbs_ram.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  item     | item_valid / item_ready    | value[6:0], last
//  result   | result_valid / result_ready| sorted_value[6:0], final_res, dropped
//
// Loading accepts one transaction per cycle; item_ready is high only while loading.
// Sorting uses one compare unit on a two-read RAM: a compare steps through CB_RD and
// CB_CMP, a swap adds CB_SWAP, and each comb gap update steps through GAP_MUL, GAP_QUOT
// and GAP_FIX. Bubble finish is n(n-1)/2 compares.
// Readout steps through OUT_RD, OUT_LOAD and OUT_HOLD per result; OUT_HOLD waits for result_ready.
// Reset returns to loading with an empty set; the store itself is not cleared.
`default_nettype none

module comb_then_bubble_sorter_unit #(
  parameter int unsigned MAX_ITEMS = ctbs_pkg::MAX_ITEMS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_ready,
  input  wire logic [ctbs_pkg::VALUE_W-1:0] value,
  input  wire logic                         last,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic      [ctbs_pkg::VALUE_W-1:0] sorted_value,
  output logic                              final_res,
  output logic                              dropped
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned PW = CW + ctbs_pkg::RECIP_W;
  localparam int unsigned XW = CW + ctbs_pkg::GAP_NUM_W;

  typedef enum logic [3:0] {
    LOAD, CB_START, GAP_MUL, GAP_QUOT, GAP_FIX, CB_RD, CB_CMP, CB_SWAP, CB_END,
    BB_START, OUT_RD, OUT_LOAD, OUT_HOLD
  } state_t;

  state_t state;

  logic [CW-1:0] count;
  logic          overflow;
  logic          bubble;
  logic [CW-1:0] gap;
  logic [CW-1:0] limit;
  logic [CW-1:0] last_swap;
  logic [CW-1:0] idx;
  logic [PW-1:0] gap_prod;
  logic [CW-1:0] gap_q;
  logic [ctbs_pkg::VALUE_W-1:0] held;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ctbs_pkg::VALUE_W-1:0] ram_wdata;
  logic [ctbs_pkg::VALUE_W-1:0] rd_a;
  logic [ctbs_pkg::VALUE_W-1:0] rd_b;

  logic [CW:0]   idx_far;
  logic          pass_more;
  logic          swap_hit;
  logic          store_full;
  logic [XW-1:0] gap_rem;
  logic [CW-1:0] gap_fixed;
  logic [CW-1:0] gap_new;
  logic [CW-1:0] end_limit;

  assign item_ready   = (state == LOAD);
  assign result_valid = (state == OUT_HOLD);

  assign idx_far    = (CW+1)'(idx) + (CW+1)'(gap);
  assign pass_more  = idx_far < (CW+1)'(limit);
  assign store_full = (count >= CW'(MAX_ITEMS));
  assign swap_hit   = bubble ? (rd_a > rd_b)
                             : (ctbs_pkg::tens_digit(rd_a) > ctbs_pkg::tens_digit(rd_b));

  assign gap_rem   = XW'(gap) * XW'(ctbs_pkg::GAP_NUM) - XW'(gap_q) * XW'(ctbs_pkg::GAP_DEN);
  assign gap_fixed = (gap_rem >= XW'(ctbs_pkg::GAP_DEN)) ? gap_q + CW'(1) : gap_q;
  assign gap_new   = (gap_fixed == '0) ? CW'(1) : gap_fixed;

  always_comb begin
    if (bubble) begin
      end_limit = limit - CW'(1);
    end else if (gap == CW'(1)) begin
      end_limit = last_swap + CW'(1);
    end else begin
      end_limit = limit;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = value;
    case (state)
      LOAD: begin
        ram_we = item_valid && !store_full;
      end
      CB_CMP: begin
        ram_we    = swap_hit;
        ram_waddr = idx[AW-1:0];
        ram_wdata = rd_b;
      end
      CB_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_far[AW-1:0];
        ram_wdata = held;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ctbs_ram #(
    .WIDTH (ctbs_pkg::VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (idx[AW-1:0]),
    .raddr_b (idx_far[AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= LOAD;
      count    <= '0;
      overflow <= 1'b0;
      bubble   <= 1'b0;
    end else begin
      case (state)
        LOAD: begin
          if (item_valid) begin
            if (!store_full) begin
              count <= count + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (last) begin
              state <= CB_START;
            end
          end
        end
        CB_START: begin
          gap    <= count;
          limit  <= count;
          bubble <= 1'b0;
          idx    <= '0;
          state  <= (count > CW'(1)) ? GAP_MUL : BB_START;
        end
        GAP_MUL: begin
          gap_prod <= PW'(gap) * PW'(ctbs_pkg::GAP_RECIP);
          state    <= GAP_QUOT;
        end
        GAP_QUOT: begin
          gap_q <= CW'(gap_prod >> ctbs_pkg::RECIP_SHIFT);
          state <= GAP_FIX;
        end
        GAP_FIX: begin
          gap       <= gap_new;
          idx       <= '0;
          last_swap <= '0;
          state     <= CB_RD;
        end
        CB_RD: begin
          state <= pass_more ? CB_CMP : CB_END;
        end
        CB_CMP: begin
          if (swap_hit) begin
            held      <= rd_a;
            last_swap <= idx;
            state     <= CB_SWAP;
          end else begin
            idx   <= idx + CW'(1);
            state <= CB_RD;
          end
        end
        CB_SWAP: begin
          idx   <= idx + CW'(1);
          state <= CB_RD;
        end
        CB_END: begin
          idx <= '0;
          if (end_limit > CW'(1)) begin
            limit <= end_limit;
            state <= bubble ? CB_RD : GAP_MUL;
          end else begin
            state <= bubble ? OUT_RD : BB_START;
          end
        end
        BB_START: begin
          bubble <= 1'b1;
          gap    <= CW'(1);
          limit  <= count;
          idx    <= '0;
          state  <= (count > CW'(1)) ? CB_RD : OUT_RD;
        end
        OUT_RD: begin
          state <= OUT_LOAD;
        end
        OUT_LOAD: begin
          sorted_value <= rd_a;
          final_res    <= ((idx + CW'(1)) == count);
          dropped      <= overflow;
          state        <= OUT_HOLD;
        end
        OUT_HOLD: begin
          if (result_ready) begin
            if (final_res) begin
              count    <= '0;
              overflow <= 1'b0;
              bubble   <= 1'b0;
              state    <= LOAD;
            end else begin
              idx   <= idx + CW'(1);
              state <= OUT_RD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("item_ready and result_valid high together");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count above capacity");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && final_res) |=> (count == '0 && !overflow && item_ready))
    else $error("set not cleared after final transaction");

  a_bubble_gap: assert property (@(posedge clk) disable iff (rst)
    (bubble && state == CB_RD) |-> (gap == CW'(1)))
    else $error("bubble pass with gap other than one");

endmodule

`default_nettype wire
